// ===== rtl/gr1_pkg.sv =====
`timescale 1ns / 1ps

package gr1_pkg;

  localparam logic [1:0] OP_CLEAR = 2'd0;
  localparam logic [1:0] OP_DRAW  = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  localparam int GLYPH_COLS  = 5;
  localparam int GLYPH_ROWS  = 7;
  localparam int ROM_FIRST   = 32;
  localparam int ROM_COUNT   = 59;
  localparam int ROM_IDX_W   = $clog2(ROM_COUNT);

  // Five columns of one glyph, bit 0 of each column is the top row.
  typedef logic [GLYPH_COLS-1:0][7:0] glyph_t;

  localparam logic [7:0] GLYPH_ROM [ROM_COUNT][GLYPH_COLS] = '{
    '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h00, 8'h00, 8'h5F, 8'h00, 8'h00},
    '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h14, 8'h7F, 8'h14, 8'h7F, 8'h14},
    '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h23, 8'h13, 8'h08, 8'h64, 8'h62},
    '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h00, 8'h1C, 8'h22, 8'h41, 8'h00},
    '{8'h00, 8'h41, 8'h22, 8'h1C, 8'h00},
    '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h08, 8'h08, 8'h3E, 8'h08, 8'h08},
    '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h08, 8'h08, 8'h08, 8'h08, 8'h08},
    '{8'h00, 8'h60, 8'h60, 8'h00, 8'h00},
    '{8'h20, 8'h10, 8'h08, 8'h04, 8'h02},
    '{8'h3E, 8'h51, 8'h49, 8'h45, 8'h3E},
    '{8'h00, 8'h42, 8'h7F, 8'h40, 8'h00},
    '{8'h42, 8'h61, 8'h51, 8'h49, 8'h46},
    '{8'h21, 8'h41, 8'h45, 8'h4B, 8'h31},
    '{8'h18, 8'h14, 8'h12, 8'h7F, 8'h10},
    '{8'h27, 8'h45, 8'h45, 8'h45, 8'h39},
    '{8'h3C, 8'h4A, 8'h49, 8'h49, 8'h30},
    '{8'h01, 8'h71, 8'h09, 8'h05, 8'h03},
    '{8'h36, 8'h49, 8'h49, 8'h49, 8'h36},
    '{8'h06, 8'h49, 8'h49, 8'h29, 8'h1E},
    '{8'h00, 8'h36, 8'h36, 8'h00, 8'h00},
    '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h14, 8'h14, 8'h14, 8'h14, 8'h14},
    '{8'h00, 8'h41, 8'h22, 8'h14, 8'h08},
    '{8'h02, 8'h01, 8'h51, 8'h09, 8'h06},
    '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h7E, 8'h11, 8'h11, 8'h11, 8'h7E},
    '{8'h7F, 8'h49, 8'h49, 8'h49, 8'h36},
    '{8'h3E, 8'h41, 8'h41, 8'h41, 8'h22},
    '{8'h7F, 8'h41, 8'h41, 8'h22, 8'h1C},
    '{8'h7F, 8'h49, 8'h49, 8'h49, 8'h41},
    '{8'h7F, 8'h09, 8'h09, 8'h09, 8'h01},
    '{8'h3E, 8'h41, 8'h49, 8'h49, 8'h7A},
    '{8'h7F, 8'h08, 8'h08, 8'h08, 8'h7F},
    '{8'h00, 8'h41, 8'h7F, 8'h41, 8'h00},
    '{8'h20, 8'h40, 8'h41, 8'h3F, 8'h01},
    '{8'h7F, 8'h08, 8'h14, 8'h22, 8'h41},
    '{8'h7F, 8'h40, 8'h40, 8'h40, 8'h40},
    '{8'h7F, 8'h02, 8'h0C, 8'h02, 8'h7F},
    '{8'h7F, 8'h04, 8'h08, 8'h10, 8'h7F},
    '{8'h3E, 8'h41, 8'h41, 8'h41, 8'h3E},
    '{8'h7F, 8'h09, 8'h09, 8'h09, 8'h06},
    '{8'h3E, 8'h41, 8'h51, 8'h21, 8'h5E},
    '{8'h7F, 8'h09, 8'h19, 8'h29, 8'h46},
    '{8'h46, 8'h49, 8'h49, 8'h49, 8'h31},
    '{8'h01, 8'h01, 8'h7F, 8'h01, 8'h01},
    '{8'h3F, 8'h40, 8'h40, 8'h40, 8'h3F},
    '{8'h1F, 8'h20, 8'h40, 8'h20, 8'h1F},
    '{8'h3F, 8'h40, 8'h38, 8'h40, 8'h3F},
    '{8'h63, 8'h14, 8'h08, 8'h14, 8'h63},
    '{8'h07, 8'h08, 8'h70, 8'h08, 8'h07},
    '{8'h61, 8'h51, 8'h49, 8'h45, 8'h43}
  };

  // Lowercase folds to uppercase; codes without a glyph give a blank cell.
  function automatic glyph_t glyph_lookup(input logic [7:0] code);
    logic [7:0]           folded;
    logic [7:0]           offset;
    logic [ROM_IDX_W-1:0] idx;
    glyph_t               g;
    folded = code;
    if ((code >= 8'h61) && (code <= 8'h7A)) begin
      folded = code - 8'(ROM_FIRST);
    end
    offset = folded - 8'(ROM_FIRST);
    idx    = offset[ROM_IDX_W-1:0];
    g      = '0;
    if ((folded >= 8'(ROM_FIRST)) && (folded < 8'(ROM_FIRST + ROM_COUNT))) begin
      for (int c = 0; c < GLYPH_COLS; c++) begin
        g[c] = GLYPH_ROM[idx][c];
      end
    end
    return g;
  endfunction

endpackage

// ===== rtl/glyph_rasterizer_1bpp_top.sv =====
`timescale 1ns / 1ps

// 5x7 character generator writing into a 1-bit-per-pixel frame store (bit 1 = white).
// Input beats carry one operation in in_tuser: clear the store, draw one glyph
// with its top-left corner at (x_pos, y_pos), or read one store byte. Every
// beat gives exactly one output beat with read_byte and op_done.
// A draw walks the seven glyph rows and the two store bytes each row can touch,
// one at a time through a single read-modify-write path: a byte slot with no
// lit pixel ends in S_CALC, and one that is written passes through S_CALC,
// S_ADDR, S_READ and S_WRITE.
// in_tready is high only while no operation is in progress.
// Reset starts a clearing pass that writes 0xFF to every store byte, one byte
// a cycle; no input beat is taken until it ends.
// A finished result sits in an output register; the next input beat may be
// taken while it waits, and a later result holds the sequencer until the
// receiver has taken the earlier one.
module glyph_rasterizer_1bpp_top #(
  parameter int PANEL_WIDTH  = 176,
  parameter int PANEL_HEIGHT = 264,
  parameter int STORE_BYTES  = 5808
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // x_pos[9:0], y_pos[19:10], char_code[27:20],
                                  // byte_index[40:28], zero fill
  input  logic [1:0]  in_tuser,   // opcode[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata   // read_byte[7:0], op_done[8], zero fill
);
  import gr1_pkg::*;

  localparam int ROW_BYTES = (PANEL_WIDTH + 7) / 8;
  localparam int AW        = $clog2(STORE_BYTES);
  localparam int FA_W      = $clog2(PANEL_HEIGHT * ROW_BYTES + 1);

  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_CALC   = 3'd2;
  localparam logic [2:0] S_ADDR   = 3'd3;
  localparam logic [2:0] S_READ   = 3'd4;
  localparam logic [2:0] S_WRITE  = 3'd5;
  localparam logic [2:0] S_RDWAIT = 3'd6;
  localparam logic [2:0] S_DONE   = 3'd7;

  logic [2:0]      state_r, state_nxt;
  logic [AW-1:0]   clr_cnt_r, clr_cnt_nxt;
  logic            clr_op_r, clr_op_nxt;
  logic [9:0]      x_r, x_nxt;
  logic [9:0]      y_r, y_nxt;
  glyph_t          glyph_r, glyph_nxt;
  logic [2:0]      row_r, row_nxt;
  logic            slot_r, slot_nxt;
  logic [FA_W-1:0] prod_r, prod_nxt;
  logic [6:0]      bslot_r, bslot_nxt;
  logic [7:0]      mask_r, mask_nxt;
  logic [AW-1:0]   addr_r, addr_nxt;
  logic [7:0]      res_byte_r, res_byte_nxt;
  logic            res_done_r, res_done_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic [8:0]      out_data_r, out_data_nxt;

  logic            ram_we;
  logic [AW-1:0]   ram_wa;
  logic [7:0]      ram_wd;
  logic            ram_re;
  logic [AW-1:0]   ram_ra;
  logic [7:0]      ram_rd;

  logic [9:0]      in_x, in_y;
  logic [7:0]      in_char;
  logic [12:0]     in_idx;
  logic [1:0]      in_op;
  logic            in_fire;
  logic            idx_ok;
  logic            out_free;
  logic            last_unit;

  logic [10:0]     y_row;
  logic            y_ok;
  logic [7:0]      bslot;
  logic            b_ok;
  logic [7:0]      mask_calc;
  logic [FA_W-1:0] rowoff;
  logic [FA_W-1:0] addr_full;
  logic            addr_ok;

  assign in_x    = in_tdata[9:0];
  assign in_y    = in_tdata[19:10];
  assign in_char = in_tdata[27:20];
  assign in_idx  = in_tdata[40:28];
  assign in_op   = in_tuser;

  assign in_tready = (state_r == S_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign idx_ok    = (32'(in_idx) < 32'(STORE_BYTES));
  assign out_free  = !out_valid_r || out_tready;
  assign last_unit = (row_r == 3'(GLYPH_ROWS - 1)) && slot_r;

  // Mask for one glyph row within one store byte. The byte slot is the one
  // holding the glyph's left column, or the one after it.
  always_comb begin
    logic [10:0] px;
    logic [11:0] c;
    logic        lit;
    y_row = {y_r[9], y_r} + {8'd0, row_r};
    y_ok  = !y_row[10] && ({1'b0, y_row} < 12'(PANEL_HEIGHT));
    bslot = {x_r[9], x_r[9:3]} + {7'd0, slot_r};
    b_ok  = !bslot[7] && ({1'b0, bslot} < 9'(ROW_BYTES));
    for (int k = 0; k < 8; k++) begin
      px  = {bslot, 3'(k)};
      c   = {px[10], px} - {{2{x_r[9]}}, x_r};
      lit = (c[11:3] == 9'd0) && (c[2:0] <= 3'd4) &&
            ({1'b0, px} < 12'(PANEL_WIDTH));
      mask_calc[7-k] = b_ok && y_ok && lit && glyph_r[c[2:0]][row_r];
    end
    rowoff    = FA_W'(PANEL_HEIGHT - 1) - FA_W'(y_row);
    addr_full = prod_r + FA_W'(bslot_r);
    addr_ok   = (32'(addr_full) < 32'(STORE_BYTES));
  end

  always_comb begin
    state_nxt     = state_r;
    clr_cnt_nxt   = clr_cnt_r;
    clr_op_nxt    = clr_op_r;
    x_nxt         = x_r;
    y_nxt         = y_r;
    glyph_nxt     = glyph_r;
    row_nxt       = row_r;
    slot_nxt      = slot_r;
    prod_nxt      = prod_r;
    bslot_nxt     = bslot_r;
    mask_nxt      = mask_r;
    addr_nxt      = addr_r;
    res_byte_nxt  = res_byte_r;
    res_done_nxt  = res_done_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    ram_we        = 1'b0;
    ram_wa        = addr_r;
    ram_wd        = ram_rd & ~mask_r;
    ram_re        = 1'b0;
    ram_ra        = addr_r;

    unique case (state_r)
      S_CLEAR: begin
        ram_we      = 1'b1;
        ram_wa      = clr_cnt_r;
        ram_wd      = 8'hFF;
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == AW'(STORE_BYTES - 1)) begin
          clr_cnt_nxt  = '0;
          res_byte_nxt = 8'd0;
          res_done_nxt = 1'b1;
          state_nxt    = clr_op_r ? S_DONE : S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_fire) begin
          x_nxt     = in_x;
          y_nxt     = in_y;
          glyph_nxt = glyph_lookup(in_char);
          row_nxt   = '0;
          slot_nxt  = 1'b0;
          unique case (in_op)
            OP_CLEAR: begin
              clr_cnt_nxt = '0;
              clr_op_nxt  = 1'b1;
              state_nxt   = S_CLEAR;
            end
            OP_DRAW: begin
              state_nxt = S_CALC;
            end
            OP_READ: begin
              if (idx_ok) begin
                ram_re    = 1'b1;
                ram_ra    = AW'(in_idx);
                state_nxt = S_RDWAIT;
              end else begin
                res_byte_nxt = 8'd0;
                res_done_nxt = 1'b1;
                state_nxt    = S_DONE;
              end
            end
            default: begin
              res_byte_nxt = 8'd0;
              res_done_nxt = 1'b0;
              state_nxt    = S_DONE;
            end
          endcase
        end
      end
      S_CALC: begin
        mask_nxt  = mask_calc;
        bslot_nxt = bslot[6:0];
        prod_nxt  = rowoff * FA_W'(ROW_BYTES);
        if (mask_calc != 8'd0) begin
          state_nxt = S_ADDR;
        end else begin
          slot_nxt = !slot_r;
          if (slot_r) begin
            row_nxt = row_r + 1'b1;
          end
          if (last_unit) begin
            res_byte_nxt = 8'd0;
            res_done_nxt = 1'b1;
            state_nxt    = S_DONE;
          end
        end
      end
      S_ADDR: begin
        addr_nxt = AW'(addr_full);
        if (addr_ok) begin
          state_nxt = S_READ;
        end else begin
          slot_nxt = !slot_r;
          if (slot_r) begin
            row_nxt = row_r + 1'b1;
          end
          if (last_unit) begin
            res_byte_nxt = 8'd0;
            res_done_nxt = 1'b1;
            state_nxt    = S_DONE;
          end else begin
            state_nxt = S_CALC;
          end
        end
      end
      S_READ: begin
        ram_re    = 1'b1;
        state_nxt = S_WRITE;
      end
      S_WRITE: begin
        ram_we   = 1'b1;
        slot_nxt = !slot_r;
        if (slot_r) begin
          row_nxt = row_r + 1'b1;
        end
        if (last_unit) begin
          res_byte_nxt = 8'd0;
          res_done_nxt = 1'b1;
          state_nxt    = S_DONE;
        end else begin
          state_nxt = S_CALC;
        end
      end
      S_RDWAIT: begin
        res_byte_nxt = ram_rd;
        res_done_nxt = 1'b1;
        state_nxt    = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {res_done_r, res_byte_r};
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_cnt_r   <= '0;
      clr_op_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      clr_op_r    <= clr_op_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r        <= x_nxt;
    y_r        <= y_nxt;
    glyph_r    <= glyph_nxt;
    row_r      <= row_nxt;
    slot_r     <= slot_nxt;
    prod_r     <= prod_nxt;
    bslot_r    <= bslot_nxt;
    mask_r     <= mask_nxt;
    addr_r     <= addr_nxt;
    res_byte_r <= res_byte_nxt;
    res_done_r <= res_done_nxt;
    out_data_r <= out_data_nxt;
  end

  gr1_store_ram #(
    .DEPTH (STORE_BYTES),
    .AW    (AW)
  ) u_store (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_wa),
    .wr_data (ram_wd),
    .rd_en   (ram_re),
    .rd_addr (ram_ra),
    .rd_data (ram_rd)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, out_data_r};

`ifndef ASSERT_OFF
  // An accepted beat always moves the sequencer out of S_IDLE, so in_tready drops.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken twice in a row");

  a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (32'(ram_wa) < 32'(STORE_BYTES)))
    else $error("store write beyond last byte");

  // A draw only ever turns white pixels black in the byte it just read.
  a_draw_clears_only: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WRITE) |-> ((ram_wd | ram_rd) == ram_rd))
    else $error("draw write sets a pixel to white");

  a_no_empty_rmw: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_READ) |-> (mask_r != 8'd0))
    else $error("read-modify-write with empty mask");

  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE) && !out_free |=> (state_r == S_DONE))
    else $error("result dropped while output stalled");
`endif

endmodule

// ===== rtl/gr1_store_ram.sv =====
`timescale 1ns / 1ps

module gr1_store_ram #(
  parameter int DEPTH = 5808,
  parameter int AW    = 13
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [7:0]    wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [7:0]    rd_data
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule
